FILE: design/vertex_perspective_projection_core_macros.svh
// Assertion macros for the vertex perspective projection core.
// Included by the top level; depends on i_clk and i_rst_n in the including scope.
`ifndef VERTEX_PERSPECTIVE_PROJECTION_CORE_MACROS_SVH
`define VERTEX_PERSPECTIVE_PROJECTION_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VPP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vpp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vpp assertion failed");

`endif

FILE: design/vpp_pkg.sv
// Shared types, constants and helper functions of the vertex projection core.
// No dependencies; imported by every module of the core.
`default_nettype none

package vpp_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int COORD_FRAC      = 14;
    localparam int LANE_W          = 16;
    localparam int ROW_W           = 64;
    localparam int DIM_W           = 13;
    localparam int SCALE_W         = DIM_W + 3;
    localparam int OUT_W           = 16;
    localparam int QA_BITS         = 17;
    localparam int Q_BITS          = 19;
    localparam int MAG_W           = 19;
    localparam int MAP_W           = 21;
    localparam int CFG_IDX_W       = 3;

    localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic wz;
        logic cx_neg;
        logic cy_neg;
        logic x_neg;
        logic y_neg;
        logic x_sat;
        logic y_sat;
    } t_side;

    function automatic int clip_width(input int coord_w, input int coef_w);
        int prod_w;
        int wt_w;
        prod_w = coord_w + coef_w;
        wt_w   = coef_w + COORD_FRAC;
        return ((prod_w > wt_w) ? prod_w : wt_w) + 2;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [MAP_W-1:0] v);
        if (v > MAP_W'(OUT_MAX)) begin
            return OUT_MAX;
        end else if (v < MAP_W'(OUT_MIN)) begin
            return OUT_MIN;
        end
        return OUT_W'(v);
    endfunction

endpackage

`default_nettype wire

FILE: design/vertex_perspective_projection_core.sv
// Top level of the vertex perspective projection core: registers, pipeline and output buffer.
// Depends on vpp_pkg, vpp_clip, vpp_scale, vpp_div, vpp_map and the assertion macro header.
`default_nettype none

// The core takes one vertex per clock while o_s_tready is high and returns one screen position
// per vertex, in order. The divider resolves one quotient bit per pipeline stage for 19 bits,
// behind two matrix stages and three scaling stages and ahead of one mapping stage and the
// output register. A two-entry output buffer lets the pipeline keep accepting vertices while
// a result waits to be taken. Screen values are in 1/16 pixel; w_zero travels on the output
// tuser bit.

`include "vertex_perspective_projection_core_macros.svh"

module vertex_perspective_projection_core
    import vpp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    localparam int IN_TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ROW_W-1:0]      i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // vertex_x, vertex_y, vertex_z from the lowest bit up
    input  wire logic [IN_TDATA_W-1:0] i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // screen_x, screen_y from the lowest bit up
    output logic [2*OUT_W-1:0]         o_m_tdata,
    // w_zero
    output logic                       o_m_tuser
);

    localparam int CLIP_W = clip_width(COORD_WIDTH, COEF_WIDTH);
    localparam int REM_W  = CLIP_W + Q_BITS;

    logic [ROW_W-1:0] r_row0;
    logic [ROW_W-1:0] r_row1;
    logic [ROW_W-1:0] r_row3;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    logic [ROW_W-1:0]   w_rows [3];
    logic [SCALE_W-1:0] w_sw;
    logic [SCALE_W-1:0] w_sh;
    logic               w_en;

    logic                     w_clip_vld;
    logic signed [CLIP_W-1:0] w_clip [3];
    logic                     w_scl_vld;
    logic [REM_W-1:0]         w_num [2];
    logic [CLIP_W-1:0]        w_den;
    t_side                    w_scl_side;
    logic                     w_div_vld;
    logic [Q_BITS-1:0]        w_quo [2];
    t_side                    w_div_side;
    logic                     w_map_vld;
    logic signed [OUT_W-1:0]  w_sx;
    logic signed [OUT_W-1:0]  w_sy;
    logic                     w_wz;

    logic                     w_push;
    logic                     w_pop;
    logic                     r_out_vld;
    logic signed [OUT_W-1:0]  r_out_sx;
    logic signed [OUT_W-1:0]  r_out_sy;
    logic                     r_out_wz;
    logic                     r_skd_vld;
    logic signed [OUT_W-1:0]  r_skd_sx;
    logic signed [OUT_W-1:0]  r_skd_sy;
    logic                     r_skd_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0   <= ROW0_RST;
            r_row1   <= ROW1_RST;
            r_row3   <= ROW3_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_ROW0:   r_row0   <= i_cfg_wdata;
                REG_ROW1:   r_row1   <= i_cfg_wdata;
                REG_ROW2:   ;
                REG_ROW3:   r_row3   <= i_cfg_wdata;
                REG_WIDTH:  r_width  <= i_cfg_wdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_wdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    assign w_rows[0] = r_row0;
    assign w_rows[1] = r_row1;
    assign w_rows[2] = r_row3;
    assign w_sw      = {r_width, 3'b000};
    assign w_sh      = {r_height, 3'b000};

    assign w_en       = !r_skd_vld;
    assign o_s_tready = w_en;

    vpp_clip #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_vx    (signed'(i_s_tdata[COORD_WIDTH-1:0])),
        .i_vy    (signed'(i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .i_vz    (signed'(i_s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
        .i_row   (w_rows),
        .o_valid (w_clip_vld),
        .o_clip  (w_clip)
    );

    vpp_scale #(
        .CLIP_W (CLIP_W)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_clip_vld),
        .i_clip  (w_clip),
        .i_sw    (w_sw),
        .i_sh    (w_sh),
        .o_valid (w_scl_vld),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_side  (w_scl_side)
    );

    vpp_div #(
        .CLIP_W (CLIP_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_scl_vld),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (w_scl_side),
        .o_valid (w_div_vld),
        .o_quo   (w_quo),
        .o_side  (w_div_side)
    );

    vpp_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_vld),
        .i_quo   (w_quo),
        .i_side  (w_div_side),
        .i_sw    (w_sw),
        .i_sh    (w_sh),
        .o_valid (w_map_vld),
        .o_sx    (w_sx),
        .o_sy    (w_sy),
        .o_wz    (w_wz)
    );

    assign w_push = w_en && w_map_vld;
    assign w_pop  = r_out_vld && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (w_push) begin
            if (!r_out_vld || w_pop) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skd_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_vld <= r_skd_vld;
            r_skd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            if (!r_out_vld || w_pop) begin
                r_out_sx <= w_sx;
                r_out_sy <= w_sy;
                r_out_wz <= w_wz;
            end else begin
                r_skd_sx <= w_sx;
                r_skd_sy <= w_sy;
                r_skd_wz <= w_wz;
            end
        end else if (w_pop) begin
            r_out_sx <= r_skd_sx;
            r_out_sy <= r_skd_sy;
            r_out_wz <= r_skd_wz;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_sy, r_out_sx};
    assign o_m_tuser  = r_out_wz;

    `VPP_ASSERT_SAME(a_skid_behind_out, r_skd_vld, r_out_vld)
    `VPP_ASSERT_SAME(a_wz_saturates, r_out_vld && r_out_wz, (r_out_sx == OUT_MAX || r_out_sx == OUT_MIN))
    `VPP_ASSERT_NEXT(a_push_blocked_fills_skid, w_push && r_out_vld && !w_pop, r_skd_vld)

endmodule

`default_nettype wire

FILE: design/vpp_clip.sv
// Matrix stage: clip x, y and w from the vertex and three matrix rows.
// Two register stages (lane products, then row sums); uses vpp_pkg.
`default_nettype none

module vpp_clip
    import vpp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    localparam int CLIP_W     = clip_width(COORD_WIDTH, COEF_WIDTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic signed [COORD_WIDTH-1:0] i_vx,
    input  wire logic signed [COORD_WIDTH-1:0] i_vy,
    input  wire logic signed [COORD_WIDTH-1:0] i_vz,
    input  wire logic        [ROW_W-1:0]       i_row [3],
    output logic                               o_valid,
    output logic signed      [CLIP_W-1:0]      o_clip [3]
);

    localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
    localparam int WT_W   = COEF_WIDTH + COORD_FRAC;

    logic signed [COORD_WIDTH-1:0] w_v [3];
    logic signed [PROD_W-1:0]      n_prod [3][3];
    logic signed [PROD_W-1:0]      r_prod [3][3];
    logic signed [WT_W-1:0]        n_wt [3];
    logic signed [WT_W-1:0]        r_wt [3];
    logic signed [CLIP_W-1:0]      n_clip [3];
    logic signed [CLIP_W-1:0]      r_clip [3];
    logic                          r_vld1;
    logic                          r_vld2;

    assign w_v[0] = i_vx;
    assign w_v[1] = i_vy;
    assign w_v[2] = i_vz;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[r][k] = signed'(i_row[r][k*LANE_W +: COEF_WIDTH]) * w_v[k];
            end
            n_wt[r] = WT_W'(signed'(i_row[r][3*LANE_W +: COEF_WIDTH])) <<< COORD_FRAC;
            n_clip[r] = CLIP_W'(r_prod[r][0]) + CLIP_W'(r_prod[r][1])
                      + CLIP_W'(r_prod[r][2]) + CLIP_W'(r_wt[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_wt   <= n_wt;
            r_clip <= n_clip;
        end
    end

    assign o_valid = r_vld2;
    assign o_clip  = r_clip;

endmodule

`default_nettype wire

FILE: design/vpp_scale.sv
// Scaling stage: magnitudes and signs, numerator times viewport scale, range checks.
// Three register stages; uses vpp_pkg.
`default_nettype none

module vpp_scale
    import vpp_pkg::*;
#(
    parameter int CLIP_W = clip_width(COORD_WIDTH_DEF, COEF_WIDTH_DEF),
    localparam int REM_W = CLIP_W + Q_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic signed [CLIP_W-1:0] i_clip [3],
    input  wire logic        [SCALE_W-1:0] i_sw,
    input  wire logic        [SCALE_W-1:0] i_sh,
    output logic                          o_valid,
    output logic             [REM_W-1:0]  o_num [2],
    output logic             [CLIP_W-1:0] o_den,
    output t_side                         o_side
);

    localparam int LO_W   = (CLIP_W + 1) / 2;
    localparam int HI_W   = CLIP_W - LO_W;
    localparam int PLO_W  = LO_W + SCALE_W;
    localparam int PHI_W  = HI_W + SCALE_W;
    localparam int PROD_W = CLIP_W + SCALE_W;

    logic [SCALE_W-1:0] w_scale [2];

    logic              r_vld_a;
    logic [CLIP_W-1:0] n_mag_a [2];
    logic [CLIP_W-1:0] r_mag_a [2];
    logic [CLIP_W-1:0] n_den_a;
    logic [CLIP_W-1:0] r_den_a;
    t_side             n_side_a;
    t_side             r_side_a;

    logic              r_vld_b;
    logic [PLO_W-1:0]  n_plo_b [2];
    logic [PLO_W-1:0]  r_plo_b [2];
    logic [PHI_W-1:0]  n_phi_b [2];
    logic [PHI_W-1:0]  r_phi_b [2];
    logic [CLIP_W-1:0] r_den_b;
    t_side             n_side_b;
    t_side             r_side_b;

    logic              r_vld_c;
    logic [PROD_W-1:0] w_prod [2];
    logic [REM_W-1:0]  n_num_c [2];
    logic [REM_W-1:0]  r_num_c [2];
    logic [CLIP_W-1:0] r_den_c;
    t_side             n_side_c;
    t_side             r_side_c;

    assign w_scale[0] = i_sw;
    assign w_scale[1] = i_sh;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_mag_a[l] = i_clip[l][CLIP_W-1] ? CLIP_W'(-i_clip[l]) : CLIP_W'(i_clip[l]);
        end
        n_den_a = i_clip[2][CLIP_W-1] ? CLIP_W'(-i_clip[2]) : CLIP_W'(i_clip[2]);
        n_side_a        = '0;
        n_side_a.wz     = (i_clip[2] == '0);
        n_side_a.cx_neg = i_clip[0][CLIP_W-1];
        n_side_a.cy_neg = i_clip[1][CLIP_W-1];
        n_side_a.x_neg  = i_clip[0][CLIP_W-1] ^ i_clip[2][CLIP_W-1];
        n_side_a.y_neg  = i_clip[1][CLIP_W-1] ^ i_clip[2][CLIP_W-1];
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_plo_b[l] = PLO_W'(r_mag_a[l][LO_W-1:0]) * PLO_W'(w_scale[l]);
            n_phi_b[l] = PHI_W'(r_mag_a[l][CLIP_W-1:LO_W]) * PHI_W'(w_scale[l]);
        end
        n_side_b       = r_side_a;
        n_side_b.x_sat = {QA_BITS'(0), r_mag_a[0]} >= {r_den_a, QA_BITS'(0)};
        n_side_b.y_sat = {QA_BITS'(0), r_mag_a[1]} >= {r_den_a, QA_BITS'(0)};
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_prod[l]  = (PROD_W'(r_phi_b[l]) << LO_W) + PROD_W'(r_plo_b[l]);
            n_num_c[l] = REM_W'({w_prod[l], 1'b0});
        end
        n_side_c       = r_side_b;
        n_side_c.x_sat = r_side_b.x_sat || (n_num_c[0] >= {r_den_b, Q_BITS'(0)});
        n_side_c.y_sat = r_side_b.y_sat || (n_num_c[1] >= {r_den_b, Q_BITS'(0)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_a  <= n_mag_a;
            r_den_a  <= n_den_a;
            r_side_a <= n_side_a;
            r_plo_b  <= n_plo_b;
            r_phi_b  <= n_phi_b;
            r_den_b  <= r_den_a;
            r_side_b <= n_side_b;
            r_num_c  <= n_num_c;
            r_den_c  <= r_den_b;
            r_side_c <= n_side_c;
        end
    end

    assign o_valid = r_vld_c;
    assign o_num   = r_num_c;
    assign o_den   = r_den_c;
    assign o_side  = r_side_c;

endmodule

`default_nettype wire

FILE: design/vpp_div.sv
// Pipelined restoring divider for the x and y lanes, one quotient bit per stage.
// Shares one divisor between both lanes; uses vpp_pkg.
`default_nettype none

module vpp_div
    import vpp_pkg::*;
#(
    parameter int CLIP_W = clip_width(COORD_WIDTH_DEF, COEF_WIDTH_DEF),
    localparam int REM_W = CLIP_W + Q_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [REM_W-1:0]  i_num [2],
    input  wire logic [CLIP_W-1:0] i_den,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic      [Q_BITS-1:0] o_quo [2],
    output t_side                  o_side
);

    logic              p_vld  [Q_BITS];
    logic [REM_W-1:0]  p_rem  [Q_BITS][2];
    logic [Q_BITS-1:0] p_quo  [Q_BITS][2];
    logic [CLIP_W-1:0] p_den  [Q_BITS];
    t_side             p_side [Q_BITS];

    logic              r_vld  [Q_BITS];
    logic [REM_W-1:0]  n_rem  [Q_BITS][2];
    logic [REM_W-1:0]  r_rem  [Q_BITS][2];
    logic [Q_BITS-1:0] n_quo  [Q_BITS][2];
    logic [Q_BITS-1:0] r_quo  [Q_BITS][2];
    logic [CLIP_W-1:0] r_den  [Q_BITS];
    t_side             r_side [Q_BITS];
    logic [REM_W-1:0]  w_sub  [Q_BITS];

    assign p_vld[0]    = i_valid;
    assign p_rem[0]    = i_num;
    assign p_quo[0][0] = '0;
    assign p_quo[0][1] = '0;
    assign p_den[0]    = i_den;
    assign p_side[0]   = i_side;

    for (genvar j = 1; j < Q_BITS; j++) begin : g_link
        assign p_vld[j]  = r_vld[j-1];
        assign p_rem[j]  = r_rem[j-1];
        assign p_quo[j]  = r_quo[j-1];
        assign p_den[j]  = r_den[j-1];
        assign p_side[j] = r_side[j-1];
    end

    always_comb begin
        for (int j = 0; j < Q_BITS; j++) begin
            w_sub[j] = REM_W'(p_den[j]) << (Q_BITS - 1 - j);
            for (int l = 0; l < 2; l++) begin
                if (p_rem[j][l] >= w_sub[j]) begin
                    n_rem[j][l] = p_rem[j][l] - w_sub[j];
                    n_quo[j][l] = p_quo[j][l] | (Q_BITS'(1) << (Q_BITS - 1 - j));
                end else begin
                    n_rem[j][l] = p_rem[j][l];
                    n_quo[j][l] = p_quo[j][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < Q_BITS; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld <= p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_den  <= p_den;
            r_side <= p_side;
        end
    end

    assign o_valid = r_vld[Q_BITS-1];
    assign o_quo   = r_quo[Q_BITS-1];
    assign o_side  = r_side[Q_BITS-1];

endmodule

`default_nettype wire

FILE: design/vpp_map.sv
// Viewport mapping: rounding, sign, offset and saturation to 16-bit screen values.
// One register stage; uses vpp_pkg.
`default_nettype none

module vpp_map
    import vpp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic [Q_BITS-1:0]       i_quo [2],
    input  wire t_side                   i_side,
    input  wire logic [SCALE_W-1:0]      i_sw,
    input  wire logic [SCALE_W-1:0]      i_sh,
    output logic                         o_valid,
    output logic signed [OUT_W-1:0]      o_sx,
    output logic signed [OUT_W-1:0]      o_sy,
    output logic                         o_wz
);

    logic [Q_BITS:0]           w_round [2];
    logic [MAG_W-1:0]          w_mag   [2];
    logic signed [MAP_W-1:0]   w_sgn   [2];
    logic                      w_sat   [2];
    logic                      w_neg   [2];
    logic signed [MAP_W-1:0]   w_fx;
    logic signed [MAP_W-1:0]   w_fy;
    logic signed [OUT_W-1:0]   n_sx;
    logic signed [OUT_W-1:0]   n_sy;

    logic                      r_vld;
    logic signed [OUT_W-1:0]   r_sx;
    logic signed [OUT_W-1:0]   r_sy;
    logic                      r_wz;

    assign w_sat[0] = i_side.x_sat;
    assign w_sat[1] = i_side.y_sat;
    assign w_neg[0] = i_side.x_neg;
    assign w_neg[1] = i_side.y_neg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_round[l] = ((Q_BITS + 1)'(i_quo[l]) + (Q_BITS + 1)'(1)) >> 1;
            w_mag[l]   = w_sat[l] ? (MAG_W'(1) << (MAG_W - 1)) : MAG_W'(w_round[l]);
            w_sgn[l]   = w_neg[l] ? -signed'(MAP_W'(w_mag[l])) : signed'(MAP_W'(w_mag[l]));
        end
        w_fx = signed'(MAP_W'(i_sw)) + w_sgn[0];
        w_fy = signed'(MAP_W'(i_sh)) - w_sgn[1];
        if (i_side.wz) begin
            n_sx = i_side.cx_neg ? OUT_MIN : OUT_MAX;
            n_sy = i_side.cy_neg ? OUT_MAX : OUT_MIN;
        end else begin
            n_sx = sat_out(w_fx);
            n_sy = sat_out(w_fy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_wz <= i_side.wz;
        end
    end

    assign o_valid = r_vld;
    assign o_sx    = r_sx;
    assign o_sy    = r_sy;
    assign o_wz    = r_wz;

endmodule

`default_nettype wire

FILE: test/vpp_scoreboard.sv
// Checker for the vertex perspective projection core: predicts each screen position.
// Depends on vpp_pkg; watches the config port and both stream channels of the core.
`default_nettype none

module vpp_scoreboard
    import vpp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ROW_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    input  wire logic [47:0]          i_s_tdata,
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire logic [31:0]          i_m_tdata,
    input  wire logic                 i_m_tuser,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               wz;
    } t_screen;

    logic [ROW_W-1:0] rows [4];
    logic [DIM_W-1:0] view_w;
    logic [DIM_W-1:0] view_h;
    t_screen          screen_q[$];

    assign o_pending = screen_q.size();

    function automatic longint lane_coef(input int r, input int k);
        logic signed [15:0] c;
        c = rows[r][16*k +: 16];
        return longint'(c);
    endfunction

    function automatic longint clip_of(input int r, input longint vx, input longint vy,
                                       input longint vz);
        return lane_coef(r, 3) * 16384 + lane_coef(r, 0) * vx + lane_coef(r, 1) * vy
               + lane_coef(r, 2) * vz;
    endfunction

    // Rounded num*s/den, ties away from zero, magnitude capped at 2^40.
    function automatic longint round_ratio(input longint num, input longint den,
                                           input longint s);
        logic   neg;
        longint a, b, qa, ra, q, t;
        neg = (num < 0) != (den < 0);
        a = num < 0 ? -num : num;
        b = den < 0 ? -den : den;
        qa = a / b;
        ra = a % b;
        if (qa >= (64'sd1 << 17)) begin
            q = 64'sd1 << 40;
        end else begin
            t = ra * s;
            q = qa * s + t / b;
            if (2 * (t % b) >= b) q++;
        end
        if (q > (64'sd1 << 40)) q = 64'sd1 << 40;
        return neg ? -q : q;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic t_screen project(input logic [47:0] d);
        t_screen r;
        longint  cx, cy, cw, sw, sh;
        logic signed [15:0] vx, vy, vz;
        vx = d[15:0];
        vy = d[31:16];
        vz = d[47:32];
        cx = clip_of(0, vx, vy, vz);
        cy = clip_of(1, vx, vy, vz);
        cw = clip_of(3, vx, vy, vz);
        sw = longint'(view_w) * 8;
        sh = longint'(view_h) * 8;
        r.wz = (cw == 0);
        if (cw == 0) begin
            r.sx = cx >= 0 ? 16'sh7fff : 16'sh8000;
            r.sy = cy >= 0 ? 16'sh8000 : 16'sh7fff;
        end else begin
            r.sx = clamp16(round_ratio(cx, cw, sw) + sw);
            r.sy = clamp16(sh - round_ratio(cy, cw, sh));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_screen want;
        int      bad;
        bad = 0;
        if (!i_rst_n) begin
            rows[0] <= ROW0_RST;
            rows[1] <= ROW1_RST;
            rows[2] <= 64'h0000_1000_0000_0000;
            rows[3] <= ROW3_RST;
            view_w  <= WIDTH_RST;
            view_h  <= HEIGHT_RST;
            screen_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: rows[i_cfg_idx[1:0]] <= i_cfg_wdata;
                    REG_WIDTH:  view_w <= i_cfg_wdata[DIM_W-1:0];
                    REG_HEIGHT: view_h <= i_cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) screen_q.push_back(project(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (screen_q.size() == 0) begin
                    $error("unexpected item sx=%0d", $signed(i_m_tdata[15:0]));
                    bad++;
                end else begin
                    want = screen_q.pop_front();
                    if (want.sx !== i_m_tdata[15:0]) begin
                        $error("screen_x expected %0d actual %0d", want.sx,
                               $signed(i_m_tdata[15:0]));
                        bad++;
                    end
                    if (want.sy !== i_m_tdata[31:16]) begin
                        $error("screen_y expected %0d actual %0d", want.sy,
                               $signed(i_m_tdata[31:16]));
                        bad++;
                    end
                    if (want.wz !== i_m_tuser) begin
                        $error("w_zero expected %0d actual %0d", want.wz, i_m_tuser);
                        bad++;
                    end
                end
            end
            o_errors <= o_errors + bad;
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_vertex_perspective_projection_core.sv
// Testbench top for the vertex perspective projection core: stimulus and verdict.
// Depends on vpp_pkg, the core and the vpp_scoreboard checker.
`default_nettype none

module tb_vertex_perspective_projection_core;
    import vpp_pkg::*;

    localparam int LIMIT = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ROW_W-1:0]     i_cfg_wdata;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [47:0]          i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [31:0]          o_m_tdata;
    logic                 o_m_tuser;
    int                   errors;
    int                   pending;
    int                   cycles;
    logic                 calm;

    vertex_perspective_projection_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata), .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    vpp_scoreboard checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata), .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser), .o_errors(errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("tb_vertex_perspective_projection_core: FAIL");
                $finish;
            end
        end
    end

    // The receiver stalls in random bursts unless the run is in its calm tail.
    initial begin
        int n;
        i_m_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(2) == 0) begin
                n = $urandom_range(17, 1);
                i_m_tready <= 0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1;
            @(posedge i_clk);
        end
    end

    task automatic cfg_write(input t_cfg_reg idx, input logic [ROW_W-1:0] val);
        i_cfg_we    <= 1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic send_vertex(input logic [47:0] d);
        int n;
        if (!calm && $urandom_range(3) == 0) begin
            n = $urandom_range(17, 1);
            i_s_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(16384 + 2000, 16384 - 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] pick_row(input int r);
        logic [ROW_W-1:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(1)) begin
            v = 0;
            v[16*r +: 16] = 16'($urandom_range(6000, 2000));
            if (r == 3) v[47:32] = 16'($urandom_range(300));
            else v[63:48] = 16'($urandom_range(2000));
        end
        return v;
    endfunction

    initial begin
        logic [15:0] ext [4];
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = REG_ROW0;
        i_cfg_wdata = 0;
        i_s_tvalid = 0;
        i_s_tdata = 0;
        calm = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        ext = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000};
        for (int i = 0; i < 4; i++)
            send_vertex({ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]});
        // Origin of model space lands at the screen center.
        send_vertex(48'h0);
        drain();

        // A zero w row forces the w_zero flag for every sign of x and y.
        cfg_write(REG_ROW3, 64'h0);
        foreach (ext[i]) send_vertex({16'h0, ext[i], ext[(i + 1) % 4]});
        drain();
        // Tiny w gives saturating quotients; a zero viewport width maps x to zero.
        cfg_write(REG_ROW3, 64'h0001_0000_0000_0000);
        cfg_write(REG_WIDTH, 64'h0);
        cfg_write(REG_HEIGHT, 64'h1fff);
        cfg_write(REG_ROW2, 64'hffff_ffff_ffff_ffff);
        foreach (ext[i]) send_vertex({ext[i], ext[(i + 3) % 4], ext[(i + 1) % 4]});
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 9) calm = 1;
            cfg_write(REG_ROW0, phase == 1 ? 64'hffff_ffff_ffff_ffff : pick_row(0));
            cfg_write(REG_ROW1, phase == 1 ? 64'h8000_8000_8000_8000 : pick_row(1));
            cfg_write(REG_ROW2, pick_row(2));
            cfg_write(REG_ROW3, phase == 1 ? 64'h7fff_7fff_7fff_7fff : pick_row(3));
            cfg_write(REG_WIDTH, phase == 2 ? 64'd4096 : phase == 3 ? 64'd1
                                 : 64'($urandom_range(4096, 1)));
            cfg_write(REG_HEIGHT, phase == 2 ? 64'd4096 : phase == 3 ? 64'd1
                                  : 64'($urandom_range(4096, 1)));
            for (int i = 0; i < 50; i++) send_vertex({pick16(), pick16(), pick16()});
            drain();
        end

        if (errors == 0) begin
            $display("tb_vertex_perspective_projection_core: PASS");
        end else begin
            $display("tb_vertex_perspective_projection_core: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
